// ----- hdl/schedule_setpoint_ramper_assert.svh -----
// ---------------------------------------------------------------------------
// Schedule setpoint ramper assertion macros
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SCHEDULE_SETPOINT_RAMPER_ASSERT_SVH
`define SCHEDULE_SETPOINT_RAMPER_ASSERT_SVH

// Same-cycle implication.
`define SSR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("schedule_setpoint_ramper: assertion failed");

// Next-cycle implication.
`define SSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("schedule_setpoint_ramper: assertion failed");

`endif

// ----- hdl/ssr_pkg.sv -----
// ---------------------------------------------------------------------------
// Schedule setpoint ramper package
// Payload types, field widths and register indexes shared by the block.
// ---------------------------------------------------------------------------
package ssr_pkg;

  localparam int NumPointsDef = 4;   // default number of schedule points
  localparam int RegPoints    = 4;   // points backed by a register
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 27;
  localparam int RampW        = 24;
  localparam int TimerW       = 25;
  localparam int ProgResW     = 3;
  localparam int ElapsedW     = 16;

  // Register indexes: points 0..RegPoints-1 sit at their own index.
  localparam logic [CfgIdxW-1:0] CfgRampIdx    = 3'd4;
  localparam logic [RampW-1:0]   RampResetMs   = 24'd300000;

  typedef struct packed {
    logic                command;
    logic [4:0]          hour;
    logic [5:0]          minute;
    logic [ElapsedW-1:0] elapsed_ms;
  } ssr_in_t;

  typedef struct packed {
    logic [ProgResW-1:0] program_res;
    logic signed [7:0]   cooling_setpoint;
    logic signed [7:0]   heating_setpoint;
  } ssr_res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } ssr_cfg_t;

endpackage

// ----- hdl/ssr_chan_if.sv -----
// ---------------------------------------------------------------------------
// Schedule setpoint ramper channel
// Valid/ready channel with a typed payload; one transfer per edge with both high.
// ---------------------------------------------------------------------------
interface ssr_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/schedule_setpoint_ramper.sv -----
// ---------------------------------------------------------------------------
// Schedule setpoint ramper
// Pipeline: an input transfer enters the input register, then the result
//   register; back-to-back items give one result a cycle unless res_o stalls.
// Throughput: one item per cycle unless res_o stalls; one state update per item.
// Reset (async, active low): points cleared, ramp interval 300000 ms, last
//   point active, setpoints and ramp timer zero, both pipeline stages empty.
// ---------------------------------------------------------------------------
`include "schedule_setpoint_ramper_assert.svh"

module schedule_setpoint_ramper #(
  parameter int NUM_POINTS = ssr_pkg::NumPointsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssr_chan_if.sink     cfg_i,
  ssr_chan_if.sink     in_i,
  ssr_chan_if.source   res_o
);
  import ssr_pkg::*;

  localparam int IdxW      = $clog2(NUM_POINTS);
  localparam int ProgW     = IdxW + 1;
  localparam int StoredPts = (NUM_POINTS < RegPoints) ? NUM_POINTS : RegPoints;

  // -------------------------------------------------------------------------
  // Configuration registers. Always ready; ignore writes to unbacked indexes.
  // -------------------------------------------------------------------------
  logic                cfg_we;
  logic [CfgDataW-1:0] pts_q [StoredPts];
  logic [RampW-1:0]    ramp_q;
  logic [CfgDataW-1:0] pt_w  [NUM_POINTS];

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  for (genvar i = 0; i < NUM_POINTS; i++) begin : g_pt
    if (i < StoredPts) begin : g_reg
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          pts_q[i] <= '0;
        end else if (cfg_we && cfg_i.data.index == CfgIdxW'(i)) begin
          pts_q[i] <= cfg_i.data.value;
        end
      end
      assign pt_w[i] = pts_q[i];
    end else begin : g_zero
      // Points past the register set read as 00:00 with zero targets.
      assign pt_w[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q <= RampResetMs;
    end else if (cfg_we && cfg_i.data.index == CfgRampIdx) begin
      ramp_q <= cfg_i.data.value[RampW-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Input register: hold one item, advance when the result register frees up.
  // -------------------------------------------------------------------------
  logic    s1_valid_q;
  ssr_in_t s1_q;
  logic    s1_adv;
  logic    res_valid_q;
  ssr_res_t res_q;

  assign s1_adv     = s1_valid_q && (!res_valid_q || res_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q <= in_i.data;
    end
  end

  // -------------------------------------------------------------------------
  // Point selection: each interval test is independent; a later match wins,
  // and the wrap-around test for the last point wins over all of them.
  // -------------------------------------------------------------------------
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] idx_d;
  logic            wrap_hit;
  logic [4:0]      last_h;
  logic [5:0]      last_m;
  logic [4:0]      first_h;
  logic [5:0]      first_m;

  assign last_h  = pt_w[NUM_POINTS-1][4:0];
  assign last_m  = pt_w[NUM_POINTS-1][10:5];
  assign first_h = pt_w[0][4:0];
  assign first_m = pt_w[0][10:5];

  assign wrap_hit = (s1_q.hour == last_h && s1_q.minute >= last_m) ||
                    (s1_q.hour > last_h) || (s1_q.hour < first_h) ||
                    (s1_q.hour == first_h && s1_q.minute < first_m);

  always_comb begin
    idx_d = idx_q;
    for (int y = 0; y < NUM_POINTS - 1; y++) begin
      if ((s1_q.hour == pt_w[y][4:0] && s1_q.minute >= pt_w[y][10:5]) ||
          (s1_q.hour > pt_w[y][4:0] && s1_q.hour < pt_w[y+1][4:0]) ||
          (s1_q.hour == pt_w[y+1][4:0] && s1_q.minute < pt_w[y+1][10:5])) begin
        idx_d = IdxW'(y);
      end
    end
    if (wrap_hit) begin
      idx_d = IdxW'(NUM_POINTS - 1);
    end
  end

  // -------------------------------------------------------------------------
  // Ramp timer: add elapsed time with saturation on every item, step when it
  // exceeds the interval, clear on a step or a start.
  // -------------------------------------------------------------------------
  logic [TimerW-1:0] timer_q;
  logic [TimerW-1:0] timer_d;
  logic [TimerW:0]   timer_sum;
  logic [TimerW-1:0] timer_sat;
  logic              ramp_step;

  assign timer_sum = {1'b0, timer_q} + (TimerW+1)'(s1_q.elapsed_ms);
  assign timer_sat = timer_sum[TimerW] ? '1 : timer_sum[TimerW-1:0];
  assign ramp_step = !s1_q.command && (timer_sat > TimerW'(ramp_q));
  assign timer_d   = (s1_q.command || ramp_step) ? '0 : timer_sat;

  // -------------------------------------------------------------------------
  // Setpoints: load targets on a start, move half a degree toward them on a step.
  // -------------------------------------------------------------------------
  logic [CfgDataW-1:0] tgt_pt;
  logic signed [7:0]   cool_tgt;
  logic signed [7:0]   heat_tgt;
  logic signed [7:0]   cool_q;
  logic signed [7:0]   heat_q;
  logic signed [7:0]   cool_d;
  logic signed [7:0]   heat_d;
  logic [ProgW-1:0]    prog_num;

  assign tgt_pt   = pt_w[idx_d];
  assign cool_tgt = signed'(tgt_pt[26:19]);
  assign heat_tgt = signed'(tgt_pt[18:11]);

  always_comb begin
    cool_d = cool_q;
    heat_d = heat_q;
    if (s1_q.command) begin
      cool_d = cool_tgt;
      heat_d = heat_tgt;
    end else if (ramp_step) begin
      if (cool_tgt > cool_q) begin
        cool_d = cool_q + 8'sd1;
      end else if (cool_tgt < cool_q) begin
        cool_d = cool_q - 8'sd1;
      end
      if (heat_tgt > heat_q) begin
        heat_d = heat_q + 8'sd1;
      end else if (heat_tgt < heat_q) begin
        heat_d = heat_q - 8'sd1;
      end
    end
  end

  // One-based point number; drop bits above the result field.
  assign prog_num = ProgW'(idx_d) + ProgW'(1);

  // Commit state as the item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= IdxW'(NUM_POINTS - 1);
      cool_q  <= '0;
      heat_q  <= '0;
      timer_q <= '0;
    end else if (s1_adv) begin
      idx_q   <= idx_d;
      cool_q  <= cool_d;
      heat_q  <= heat_d;
      timer_q <= timer_d;
    end
  end

  // -------------------------------------------------------------------------
  // Result register: hold until the transfer on the result channel.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (!res_valid_q || res_o.ready) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q.program_res      <= ProgResW'(prog_num);
      res_q.cooling_setpoint <= cool_d;
      res_q.heating_setpoint <= heat_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `SSR_ASSERT_IMPLY(a_idx_range, 1'b1, idx_q <= IdxW'(NUM_POINTS - 1))
  `SSR_ASSERT_NEXT(a_start_clears_timer, s1_adv && s1_q.command, timer_q == '0)
  `SSR_ASSERT_NEXT(a_hold_without_adv, !s1_adv,
                   $stable(cool_q) && $stable(heat_q) && $stable(timer_q) && $stable(idx_q))
  `SSR_ASSERT_NEXT(a_cool_half_step, s1_adv && !s1_q.command,
                   (cool_q == $past(cool_q)) || (cool_q == $past(cool_q) + 8'sd1) ||
                   (cool_q == $past(cool_q) - 8'sd1))
  `SSR_ASSERT_NEXT(a_heat_half_step, s1_adv && !s1_q.command,
                   (heat_q == $past(heat_q)) || (heat_q == $past(heat_q) + 8'sd1) ||
                   (heat_q == $past(heat_q) - 8'sd1))

endmodule

// ----- verif/schedule_setpoint_ramper_tb.sv -----
// ---------------------------------------------------------------------------
// Schedule setpoint ramper testbench
// Drives time-of-day items and schedule register writes through valid/ready
// channels and predicts every result with a cycle-free model of the point
// selection, ramp timer and half-degree stepping. Each result is compared
// field by field against the oldest prediction. Covers directed edge cases,
// extreme register settings, random schedules under three idling patterns,
// and a long output stall that backs up the input.
// ---------------------------------------------------------------------------
module schedule_setpoint_ramper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssr_pkg::*;

  localparam int NumPts = NumPointsDef;
  localparam int PtIdxW = $clog2(NumPts);
  localparam logic [25:0] TimerMax = 26'h1FF_FFFF;
  localparam logic [CfgIdxW-1:0] CfgIdxTop = {CfgIdxW{1'b1}};

  typedef enum logic {
    CmdTick  = 1'b0,
    CmdStart = 1'b1
  } ramp_cmd_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #2 clk_i = ~clk_i;

  ssr_chan_if #(.T(ssr_cfg_t)) cfg_if ();
  ssr_chan_if #(.T(ssr_in_t))  in_if ();
  ssr_chan_if #(.T(ssr_res_t)) res_if ();

  schedule_setpoint_ramper u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  // Predicted block state: schedule table, ramp interval, active point,
  // present setpoints and the accumulated ramp time.
  logic [CfgDataW-1:0] sched_pt [NumPts];
  logic [RampW-1:0]    ramp_ms;
  int                  prog_sel;
  logic signed [7:0]   cool_sp;
  logic signed [7:0]   heat_sp;
  logic [TimerW-1:0]   ramp_acc;

  // Setpoints expected back, oldest first.
  ssr_res_t setpoint_q [$];

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_req    = 1'b0;
  int  hold_len    = 0;
  int  hold_left   = 0;
  int  clock_min   = 0;
  bit  failed      = 1'b0;
  int  n_sent      = 0;
  int  n_checked   = 0;
  int  n_steps     = 0;
  int  n_loads     = 0;
  int  n_settings  = 0;

  // Pick the active point for a time of day, then load or ramp the setpoints.
  function automatic ssr_res_t advance_setpoints(ssr_in_t it);
    logic [25:0]       acc_sum;
    int                idx;
    logic signed [7:0] cool_tgt;
    logic signed [7:0] heat_tgt;
    logic [4:0]        h0, h1;
    logic [5:0]        m0, m1;
    ssr_res_t          r;
    acc_sum  = {1'b0, ramp_acc} + it.elapsed_ms;
    ramp_acc = (acc_sum > TimerMax) ? TimerMax[TimerW-1:0] : acc_sum[TimerW-1:0];
    // Later points override earlier ones; no match keeps the previous point.
    for (int y = 0; y + 1 < NumPts; y++) begin
      h0 = sched_pt[y][4:0];
      m0 = sched_pt[y][10:5];
      h1 = sched_pt[y+1][4:0];
      m1 = sched_pt[y+1][10:5];
      if ((it.hour == h0 && it.minute >= m0) || (it.hour > h0 && it.hour < h1) ||
          (it.hour == h1 && it.minute < m1)) begin
        prog_sel = y + 1;
      end
    end
    // The last point also covers the time before the first point.
    h0 = sched_pt[0][4:0];
    m0 = sched_pt[0][10:5];
    h1 = sched_pt[NumPts-1][4:0];
    m1 = sched_pt[NumPts-1][10:5];
    if ((it.hour == h1 && it.minute >= m1) || it.hour > h1 || it.hour < h0 ||
        (it.hour == h0 && it.minute < m0)) begin
      prog_sel = NumPts;
    end
    idx      = (prog_sel - 1) % NumPts;
    cool_tgt = sched_pt[idx][26:19];
    heat_tgt = sched_pt[idx][18:11];
    if (it.command == CmdStart) begin
      cool_sp  = cool_tgt;
      heat_sp  = heat_tgt;
      ramp_acc = '0;
      n_loads++;
    end else if (ramp_acc > ramp_ms) begin
      if (cool_tgt > cool_sp) cool_sp = cool_sp + 8'sd1;
      else if (cool_tgt < cool_sp) cool_sp = cool_sp - 8'sd1;
      if (heat_tgt > heat_sp) heat_sp = heat_sp + 8'sd1;
      else if (heat_tgt < heat_sp) heat_sp = heat_sp - 8'sd1;
      ramp_acc = '0;
      n_steps++;
    end
    r.program_res      = prog_sel[ProgResW-1:0];
    r.cooling_setpoint = cool_sp;
    r.heating_setpoint = heat_sp;
    return r;
  endfunction

  function automatic logic [CfgDataW-1:0] pack_point(int h, int m, int heat, int cool);
    logic [7:0] c8, h8;
    logic [5:0] m6;
    logic [4:0] h5;
    c8 = 8'(cool);
    h8 = 8'(heat);
    m6 = 6'(m);
    h5 = 5'(h);
    return {c8, h8, m6, h5};
  endfunction

  function automatic ssr_in_t make_item(ramp_cmd_e cmd, int h, int m, int el);
    ssr_in_t it;
    it.command    = cmd;
    it.hour       = 5'(h);
    it.minute     = 6'(m);
    it.elapsed_ms = 16'(el);
    return it;
  endfunction

  // Mostly a clock that walks forward through the day, with jumps, hits on
  // the schedule's own start times, and a few out-of-range times.
  function automatic ssr_in_t rand_item();
    ssr_in_t    it;
    int         r;
    int         p;
    int         lim;
    logic [5:0] m6;
    r = $urandom_range(99);
    if (r < 70) clock_min = (clock_min + $urandom_range(0, 20)) % 1440;
    else if (r < 90) clock_min = $urandom_range(0, 1439);
    it.hour   = 5'(clock_min / 60);
    it.minute = 6'(clock_min % 60);
    r = $urandom_range(99);
    if (r < 10) begin
      p         = $urandom_range(0, NumPts - 1);
      m6        = sched_pt[p][10:5] + 6'($urandom_range(0, 2)) - 6'd1;
      it.hour   = sched_pt[p][4:0];
      it.minute = m6;
    end else if (r < 16) begin
      it.hour   = 5'($urandom_range(0, 31));
      it.minute = 6'($urandom_range(0, 63));
    end
    it.command = ($urandom_range(99) < 5) ? CmdStart : CmdTick;
    lim = (ramp_ms > 65535) ? 65535 : int'(ramp_ms);
    r   = $urandom_range(99);
    if (r < 35) it.elapsed_ms = 16'($urandom_range(0, 65535));
    else if (r < 80) it.elapsed_ms = 16'($urandom_range(0, lim));
    else it.elapsed_ms = 16'($urandom_range(0, 1000));
    return it;
  endfunction

  // Offer one item, idling the channel at random first; leave valid high so a
  // following item can go out back to back.
  task automatic send_item(input ssr_in_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    setpoint_q.push_back(advance_setpoints(it));
    n_sent++;
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.value <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx < RegPoints) begin
      if (idx < NumPts) sched_pt[idx[PtIdxW-1:0]] = value;
    end else if (idx == CfgRampIdx) begin
      ramp_ms = value[RampW-1:0];
    end
    @(posedge clk_i);
  endtask

  // Stop offering items and hold until every predicted result has come back.
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while (n_checked < n_sent && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (n_checked < n_sent) begin
      $error("results stopped arriving: %0d sent, %0d returned", n_sent, n_checked);
      failed = 1'b1;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_schedule(input logic [CfgDataW-1:0] pts [RegPoints],
                                  input logic [RampW-1:0] interval);
    for (int i = 0; i < RegPoints; i++) cfg_write(CfgIdxW'(i), pts[i]);
    cfg_write(CfgRampIdx, CfgDataW'(interval));
    n_settings++;
  endtask

  // Mostly an ordered daily schedule; sometimes fully random packed words.
  task automatic program_random_schedule();
    logic [CfgDataW-1:0] pts [RegPoints];
    int                  tod [RegPoints];
    int                  t;
    logic [RampW-1:0]    interval;
    for (int i = 0; i < RegPoints; i++) tod[i] = $urandom_range(0, 1439);
    for (int i = 1; i < RegPoints; i++) begin
      for (int j = i; j > 0 && tod[j-1] > tod[j]; j--) begin
        t        = tod[j];
        tod[j]   = tod[j-1];
        tod[j-1] = t;
      end
    end
    for (int i = 0; i < RegPoints; i++) begin
      if ($urandom_range(99) < 25) pts[i] = CfgDataW'($urandom_range(0, 32'h7FF_FFFF));
      else pts[i] = pack_point(tod[i] / 60, tod[i] % 60, $urandom_range(0, 255),
                               $urandom_range(0, 255));
    end
    case ($urandom_range(0, 5))
      0: interval = '0;
      1: interval = RampW'($urandom_range(1, 2000));
      2: interval = RampW'($urandom_range(2001, 40000));
      3: interval = 24'd65535;
      4: interval = RampResetMs;
      default: interval = RampW'($urandom_range(100000, 24'hFF_FFFF));
    endcase
    program_schedule(pts, interval);
  endtask

  // Reset contents: all points at midnight with zero targets, 300 s interval.
  task automatic test_reset_defaults();
    send_item(make_item(CmdTick, 0, 0, 65535));
    send_item(make_item(CmdTick, 12, 30, 65535));
    send_item(make_item(CmdStart, 23, 59, 0));
    wait_drained();
  endtask

  // Hand-written schedule: selection at and around each start time, before
  // the first point, out-of-range times, the step threshold, and starts.
  task automatic test_directed_schedule();
    logic [CfgDataW-1:0] pts [RegPoints];
    pts[0] = pack_point(6, 30, 36, 50);
    pts[1] = pack_point(9, 0, -128, 127);
    pts[2] = pack_point(17, 45, 40, 44);
    pts[3] = pack_point(22, 0, 127, -128);
    program_schedule(pts, 24'd100);
    send_item(make_item(CmdStart, 5, 0, 0));
    send_item(make_item(CmdTick, 6, 29, 100));   // timer equals interval: hold
    send_item(make_item(CmdTick, 6, 30, 1));     // just past interval: step
    send_item(make_item(CmdTick, 8, 59, 65535));
    send_item(make_item(CmdTick, 9, 0, 65535));
    send_item(make_item(CmdTick, 12, 0, 101));
    send_item(make_item(CmdTick, 17, 44, 500));
    send_item(make_item(CmdTick, 17, 45, 500));
    send_item(make_item(CmdTick, 21, 59, 500));
    send_item(make_item(CmdTick, 22, 0, 500));
    send_item(make_item(CmdTick, 23, 59, 500));
    send_item(make_item(CmdTick, 31, 63, 500));
    send_item(make_item(CmdTick, 24, 0, 500));
    send_item(make_item(CmdTick, 0, 0, 500));
    send_item(make_item(CmdStart, 12, 0, 65535));
    send_item(make_item(CmdTick, 12, 60, 0));
    wait_drained();
    // Zero interval: any accumulated time at all gives a step.
    cfg_write(CfgRampIdx, '0);
    send_item(make_item(CmdTick, 10, 0, 0));
    send_item(make_item(CmdTick, 10, 0, 1));
    wait_drained();
  endtask

  // All-ones points, writes to unused indexes, and the widest interval, which
  // needs a long run of maximum elapsed times before a single step.
  task automatic test_interval_extremes();
    logic [CfgDataW-1:0] pts [RegPoints];
    for (int i = 0; i < RegPoints; i++) pts[i] = {CfgDataW{1'b1}};
    program_schedule(pts, {RampW{1'b1}});
    for (int i = int'(CfgRampIdx) + 1; i <= int'(CfgIdxTop); i++) begin
      cfg_write(CfgIdxW'(i), CfgDataW'($urandom_range(0, 32'h7FF_FFFF)));
    end
    send_item(make_item(CmdStart, 31, 63, 65535));
    repeat (260) send_item(make_item(CmdTick, $urandom_range(0, 31),
                                     $urandom_range(0, 63), 65535));
    wait_drained();
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int items);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int s = 0; s < 2; s++) begin
      wait_drained();
      program_random_schedule();
      repeat (items) send_item(rand_item());
    end
    wait_drained();
  endtask

  // Stall the result side for a long stretch while items keep coming, so the
  // block fills and pushes back on its input; then pause until all are back.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 30;
    program_random_schedule();
    hold_len = 400;
    hold_req = 1'b1;
    repeat (2) @(posedge clk_i);
    repeat (80) send_item(rand_item());
    wait_drained();
    repeat (80) send_item(rand_item());
    wait_drained();
  endtask

  // Result side: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      res_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_left = hold_len;
      hold_req  = 1'b0;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each returned result against the oldest prediction.
  always @(posedge clk_i) begin
    ssr_res_t want;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      n_checked++;
      if (setpoint_q.size() == 0) begin
        $error("unexpected result: program_res %0d cooling %0d heating %0d",
               res_if.data.program_res, $signed(res_if.data.cooling_setpoint),
               $signed(res_if.data.heating_setpoint));
        failed = 1'b1;
      end else begin
        want = setpoint_q.pop_front();
        if (res_if.data.program_res !== want.program_res) begin
          $error("program_res: expected %0d, got %0d", want.program_res,
                 res_if.data.program_res);
          failed = 1'b1;
        end
        if (res_if.data.cooling_setpoint !== want.cooling_setpoint) begin
          $error("cooling_setpoint: expected %0d, got %0d",
                 $signed(want.cooling_setpoint), $signed(res_if.data.cooling_setpoint));
          failed = 1'b1;
        end
        if (res_if.data.heating_setpoint !== want.heating_setpoint) begin
          $error("heating_setpoint: expected %0d, got %0d",
                 $signed(want.heating_setpoint), $signed(res_if.data.heating_setpoint));
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    // Hold every block input at a known value from time zero.
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    for (int i = 0; i < NumPts; i++) sched_pt[i] = '0;
    ramp_ms  = RampResetMs;
    prog_sel = NumPts;
    cool_sp  = '0;
    heat_sp  = '0;
    ramp_acc = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_defaults();
    test_directed_schedule();
    test_interval_extremes();
    test_random_phase(19, 72, 250);
    test_random_phase(72, 19, 250);
    test_random_phase(0, 0, 250);
    test_backpressure();
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (setpoint_q.size() != 0) begin
      $error("%0d expected results never arrived", setpoint_q.size());
      failed = 1'b1;
    end
    $display("Covered %0d items over %0d schedule settings: %0d results checked,",
             n_sent, n_settings, n_checked);
    $display("  %0d half-degree steps and %0d target loads predicted.", n_steps, n_loads);
    if (!failed) begin
      $display("PASS schedule_setpoint_ramper");
    end else begin
      $display("FAIL schedule_setpoint_ramper");
    end
    $finish;
  end

  // Drop the run if it hangs; the slowest correct run needs far less.
  initial begin
    #2_000_000;
    $display("FAIL schedule_setpoint_ramper");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ssr_pkg.sv
hdl/ssr_chan_if.sv
hdl/schedule_setpoint_ramper.sv
verif/schedule_setpoint_ramper_tb.sv
